// ===== rtl/jrp_pkg.sv =====
`default_nettype none

package jrp_pkg;

    // Field and beat widths
    localparam int IN_W       = 16;
    localparam int ABS_W      = 16;
    localparam int SQ_W       = 32;
    localparam int SUM_W      = 32;
    localparam int MAG_W      = 20;
    localparam int ANG_W      = 17;
    localparam int OUT_W      = MAG_W + ANG_W;
    localparam int S_TDATA_W  = 2 * IN_W;
    localparam int M_TDATA_W  = 40;

    // Square root: radicand is the squared length scaled by 2^10
    localparam int MAG_SHIFT  = 10;
    localparam int SQRT_BITS  = 2;
    localparam int SQRT_STEPS = 11;
    localparam int RAD_W      = 2 * SQRT_BITS * SQRT_STEPS;
    localparam int ROOT_W     = SQRT_BITS * SQRT_STEPS;
    localparam int REM_W      = ROOT_W + 3;

    // CORDIC vectoring datapath
    localparam int XY_SHIFT   = 14;
    localparam int XY_W       = 33;
    localparam int Z_W        = 25;
    localparam int ATAN_W     = 22;
    localparam int A_W        = 23;
    localparam int FULL_W     = 25;
    localparam int ANG_DROP   = 8;

    // Fixed pipeline sections around the core
    localparam int PREP_STAGES = 3;
    localparam int POST_STAGES = 2;

    // Angle constants, degrees Q16 and Q8
    localparam logic [Z_W-1:0]    DEG90_Q16  = 25'd5898240;
    localparam logic [FULL_W-1:0] DEG180_Q16 = 25'd11796480;
    localparam logic [FULL_W-1:0] DEG360_Q16 = 25'd23592960;
    localparam logic [FULL_W-1:0] ANG_ROUND  = 25'd128;
    localparam logic [ANG_W-1:0]  DEG0_Q8    = 17'd0;
    localparam logic [ANG_W-1:0]  DEG90_Q8   = 17'd23040;
    localparam logic [ANG_W-1:0]  DEG180_Q8  = 17'd46080;
    localparam logic [ANG_W-1:0]  DEG270_Q8  = 17'd69120;
    localparam logic [ANG_W-1:0]  DEG360_Q8  = 17'd92160;

    // Sign and axis flags of one sample pair
    typedef struct packed {
        logic x_zero;
        logic y_zero;
        logic x_neg;
        logic y_neg;
    } quad_flags_t;

    // atan(2^-i) in degrees, Q16; zero from stage 23 on
    function automatic logic [ATAN_W-1:0] atan_q16(input int idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            0:       v = 22'd2949120;
            1:       v = 22'd1740967;
            2:       v = 22'd919879;
            3:       v = 22'd466945;
            4:       v = 22'd234379;
            5:       v = 22'd117304;
            6:       v = 22'd58666;
            7:       v = 22'd29335;
            8:       v = 22'd14668;
            9:       v = 22'd7334;
            10:      v = 22'd3667;
            11:      v = 22'd1833;
            12:      v = 22'd917;
            13:      v = 22'd458;
            14:      v = 22'd229;
            15:      v = 22'd115;
            16:      v = 22'd57;
            17:      v = 22'd29;
            18:      v = 22'd14;
            19:      v = 22'd7;
            20:      v = 22'd4;
            21:      v = 22'd2;
            22:      v = 22'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/jrp_prep.sv =====
`default_nettype none

module jrp_prep
    import jrp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              adv,
    input  wire logic [IN_W-1:0]   axis_x,
    input  wire logic [IN_W-1:0]   axis_y,
    output logic [SUM_W-1:0]       sum_sq,
    output logic [ABS_W-1:0]       abs_x,
    output logic [ABS_W-1:0]       abs_y,
    output quad_flags_t            flags
);

    logic [ABS_W-1:0] abs_x_a_reg, abs_y_a_reg;
    logic [ABS_W-1:0] abs_x_b_reg, abs_y_b_reg;
    logic [ABS_W-1:0] abs_x_c_reg, abs_y_c_reg;
    logic [ABS_W-1:0] abs_x_next, abs_y_next;
    quad_flags_t      flags_a_reg, flags_b_reg, flags_c_reg, flags_next;
    logic [SQ_W-1:0]  sq_x_reg, sq_y_reg;
    logic [SUM_W-1:0] sum_reg;

    // Magnitudes and sign flags; -32768 maps to 0x8000
    always_comb
    begin
        abs_x_next        = axis_x[IN_W-1] ? (~axis_x + 1'b1) : axis_x;
        abs_y_next        = axis_y[IN_W-1] ? (~axis_y + 1'b1) : axis_y;
        flags_next.x_zero = (axis_x == '0);
        flags_next.y_zero = (axis_y == '0);
        flags_next.x_neg  = axis_x[IN_W-1];
        flags_next.y_neg  = axis_y[IN_W-1];
    end

    // Stage A: magnitudes, stage B: squares, stage C: sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            abs_x_a_reg <= abs_x_next;
            abs_y_a_reg <= abs_y_next;
            flags_a_reg <= flags_next;

            sq_x_reg    <= abs_x_a_reg * abs_x_a_reg;
            sq_y_reg    <= abs_y_a_reg * abs_y_a_reg;
            abs_x_b_reg <= abs_x_a_reg;
            abs_y_b_reg <= abs_y_a_reg;
            flags_b_reg <= flags_a_reg;

            sum_reg     <= sq_x_reg + sq_y_reg;
            abs_x_c_reg <= abs_x_b_reg;
            abs_y_c_reg <= abs_y_b_reg;
            flags_c_reg <= flags_b_reg;
        end
    end

    assign sum_sq = sum_reg;
    assign abs_x  = abs_x_c_reg;
    assign abs_y  = abs_y_c_reg;
    assign flags  = flags_c_reg;

endmodule

`default_nettype wire

// ===== rtl/jrp_sqrt.sv =====
`default_nettype none

module jrp_sqrt
    import jrp_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic              clk,
    input  wire logic              adv,
    input  wire logic [SUM_W-1:0]  sum_sq,
    output logic [ROOT_W-1:0]      root
);

    logic [RAD_W-1:0]  rad_reg  [DEPTH];
    logic [REM_W-1:0]  rem_reg  [DEPTH];
    logic [ROOT_W-1:0] root_reg [DEPTH];

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_stage
        logic [RAD_W-1:0]  rad_in,  rad_next;
        logic [REM_W-1:0]  rem_in,  rem_next;
        logic [ROOT_W-1:0] root_in, root_next;

        if (k == 0)
        begin : g_first
            assign rad_in  = {{(RAD_W-SUM_W-MAG_SHIFT){1'b0}}, sum_sq, {MAG_SHIFT{1'b0}}};
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_chain
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        if (k < SQRT_STEPS)
        begin : g_work
            // Two restoring digit steps: bring down a bit pair, try 4q+1
            always_comb
            begin
                logic [REM_W-1:0]  r;
                logic [ROOT_W-1:0] q;
                logic [RAD_W-1:0]  d;
                logic [REM_W-1:0]  trial;
                r = rem_in;
                q = root_in;
                d = rad_in;
                for (int s = 0; s < SQRT_BITS; s++)
                begin
                    r     = {r[REM_W-3:0], d[RAD_W-1 -: 2]};
                    trial = {{(REM_W-ROOT_W-2){1'b0}}, q, 2'b01};
                    if (r >= trial)
                    begin
                        r = r - trial;
                        q = {q[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[ROOT_W-2:0], 1'b0};
                    end
                    d = {d[RAD_W-3:0], 2'b00};
                end
                rad_next  = d;
                rem_next  = r;
                root_next = q;
            end
        end
        else
        begin : g_pass
            assign rad_next  = rad_in;
            assign rem_next  = rem_in;
            assign root_next = root_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg[k]  <= rad_next;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign root = root_reg[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/jrp_cordic.sv =====
`default_nettype none

module jrp_cordic
    import jrp_pkg::*;
#(
    parameter int STAGES = 16,
    parameter int DEPTH  = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  adv,
    input  wire logic [ABS_W-1:0]      abs_x,
    input  wire logic [ABS_W-1:0]      abs_y,
    input  wire quad_flags_t           flags_in,
    output logic signed [Z_W-1:0]      z,
    output quad_flags_t                flags_out
);

    logic signed [XY_W-1:0] x_reg [DEPTH];
    logic signed [XY_W-1:0] y_reg [DEPTH];
    logic signed [Z_W-1:0]  z_reg [DEPTH];
    quad_flags_t            flags_reg [DEPTH];

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_stage
        logic signed [XY_W-1:0] x_in, y_in, x_next, y_next;
        logic signed [Z_W-1:0]  z_in, z_next;
        quad_flags_t            flags_stage_in;

        if (k == 0)
        begin : g_first
            // First-quadrant vector scaled by 2^14
            assign x_in = {{(XY_W-ABS_W-XY_SHIFT){1'b0}}, abs_x, {XY_SHIFT{1'b0}}};
            assign y_in = {{(XY_W-ABS_W-XY_SHIFT){1'b0}}, abs_y, {XY_SHIFT{1'b0}}};
            assign z_in = '0;
            assign flags_stage_in = flags_in;
        end
        else
        begin : g_chain
            assign x_in = x_reg[k-1];
            assign y_in = y_reg[k-1];
            assign z_in = z_reg[k-1];
            assign flags_stage_in = flags_reg[k-1];
        end

        if (k < STAGES)
        begin : g_work
            localparam logic signed [Z_W-1:0] ATAN_K =
                {{(Z_W-ATAN_W){1'b0}}, atan_q16(k)};
            logic signed [XY_W-1:0] dx, dy;
            logic                   y_pos;

            // Rotate towards the x axis; zero y counts as not positive
            assign dx    = y_in >>> k;
            assign dy    = x_in >>> k;
            assign y_pos = !y_in[XY_W-1] && (y_in != '0);

            always_comb
            begin
                if (y_pos)
                begin
                    x_next = x_in + dx;
                    y_next = y_in - dy;
                    z_next = z_in + ATAN_K;
                end
                else
                begin
                    x_next = x_in - dx;
                    y_next = y_in + dy;
                    z_next = z_in - ATAN_K;
                end
            end
        end
        else
        begin : g_pass
            assign x_next = x_in;
            assign y_next = y_in;
            assign z_next = z_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[k]     <= x_next;
                y_reg[k]     <= y_next;
                z_reg[k]     <= z_next;
                flags_reg[k] <= flags_stage_in;
            end
        end
    end

    assign z         = z_reg[DEPTH-1];
    assign flags_out = flags_reg[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/jrp_post.sv =====
`default_nettype none

module jrp_post
    import jrp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  adv,
    input  wire logic signed [Z_W-1:0] z,
    input  wire quad_flags_t           flags,
    input  wire logic [ROOT_W-1:0]     root,
    output logic [MAG_W-1:0]           magnitude_q4,
    output logic [ANG_W-1:0]           angle_deg_q8
);

    logic [A_W-1:0]    a;
    logic [FULL_W-1:0] full_next, full_reg;
    quad_flags_t       flags_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [FULL_W-1:0] rounded;
    logic [ANG_W-1:0]  ang_q8, ang_wrap, ang_next;
    logic [ROOT_W-1:0] root_inc;
    logic [MAG_W-1:0]  mag_reg;
    logic [ANG_W-1:0]  ang_reg;

    // Clamp the first-quadrant angle to 0..90 and apply quadrant correction
    always_comb
    begin
        if (z[Z_W-1])
            a = '0;
        else if (unsigned'(z) > DEG90_Q16)
            a = DEG90_Q16[A_W-1:0];
        else
            a = z[A_W-1:0];

        if (!flags.x_neg && !flags.y_neg)
            full_next = {{(FULL_W-A_W){1'b0}}, a};
        else if (flags.x_neg && !flags.y_neg)
            full_next = DEG180_Q16 - {{(FULL_W-A_W){1'b0}}, a};
        else if (flags.x_neg)
            full_next = DEG180_Q16 + {{(FULL_W-A_W){1'b0}}, a};
        else
            full_next = DEG360_Q16 - {{(FULL_W-A_W){1'b0}}, a};
    end

    // Round to Q8, wrap below 360, override on the axes
    always_comb
    begin
        rounded  = full_reg + ANG_ROUND;
        ang_q8   = rounded[ANG_DROP +: ANG_W];
        ang_wrap = (ang_q8 >= DEG360_Q8) ? (ang_q8 - DEG360_Q8) : ang_q8;
        if (flags_reg.x_zero)
        begin
            if (flags_reg.y_zero)
                ang_next = DEG0_Q8;
            else if (flags_reg.y_neg)
                ang_next = DEG270_Q8;
            else
                ang_next = DEG90_Q8;
        end
        else if (flags_reg.y_zero)
            ang_next = flags_reg.x_neg ? DEG180_Q8 : DEG0_Q8;
        else
            ang_next = ang_wrap;
        root_inc = root_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            full_reg  <= full_next;
            flags_reg <= flags;
            root_reg  <= root;

            ang_reg   <= ang_next;
            mag_reg   <= root_inc[MAG_W:1];
        end
    end

    assign magnitude_q4 = mag_reg;
    assign angle_deg_q8 = ang_reg;

endmodule

`default_nettype wire

// ===== rtl/joystick_rect_to_polar.sv =====
// Rectangular to polar conversion of signed 16-bit joystick axis pairs. Each beat on the
// slave side carries one (x, y) pair; each beat on the master side returns the length
// (unsigned, 4 fraction bits, rounded to nearest) and the direction in degrees
// (8 fraction bits, 0 up to below 360, counterclockwise from +x). Samples on an axis give
// exactly 0, 90, 180 or 270 degrees and the origin gives 0. The block takes one pair
// every cycle while the output buffer is not full; a result leaves after its pair passes
// the stages for magnitudes, squares and sum, then the core whose length is set
// by the CORDIC stage count or by the 11 two-bit square root stages, whichever is longer,
// the angle correction and rounding registers, and the output register. A two-entry
// output buffer lets one more pair in while a result waits at the master side.
`default_nettype none

module joystick_rect_to_polar
    import jrp_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // axis_x[15:0], axis_y[31:16]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata    // magnitude_q4[19:0], angle_deg_q8[36:20]
);

    localparam int CORE_DEPTH = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
    localparam int TOTAL      = PREP_STAGES + CORE_DEPTH + POST_STAGES;
    localparam logic [MAG_W-1:0] MAG_MAX = 20'd741455;

    logic              adv;
    logic [TOTAL-1:0]  valid_reg;
    logic [SUM_W-1:0]  sum_sq;
    logic [ABS_W-1:0]  abs_x, abs_y;
    quad_flags_t       prep_flags, core_flags;
    logic [ROOT_W-1:0] root;
    logic signed [Z_W-1:0] z;
    logic [MAG_W-1:0]  magnitude_q4;
    logic [ANG_W-1:0]  angle_deg_q8;

    logic              pipe_beat, take;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;
    logic [OUT_W-1:0]  skid_data_reg, skid_data_next;
    logic [OUT_W-1:0]  pipe_data;

    // Whole pipeline moves unless the output buffer is full
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    jrp_prep u_prep (
        .clk    (clk),
        .adv    (adv),
        .axis_x (s_tdata[IN_W-1:0]),
        .axis_y (s_tdata[S_TDATA_W-1:IN_W]),
        .sum_sq (sum_sq),
        .abs_x  (abs_x),
        .abs_y  (abs_y),
        .flags  (prep_flags)
    );

    jrp_sqrt #(
        .DEPTH (CORE_DEPTH)
    ) u_sqrt (
        .clk    (clk),
        .adv    (adv),
        .sum_sq (sum_sq),
        .root   (root)
    );

    jrp_cordic #(
        .STAGES (CORDIC_STAGES),
        .DEPTH  (CORE_DEPTH)
    ) u_cordic (
        .clk       (clk),
        .adv       (adv),
        .abs_x     (abs_x),
        .abs_y     (abs_y),
        .flags_in  (prep_flags),
        .z         (z),
        .flags_out (core_flags)
    );

    jrp_post u_post (
        .clk          (clk),
        .adv          (adv),
        .z            (z),
        .flags        (core_flags),
        .root         (root),
        .magnitude_q4 (magnitude_q4),
        .angle_deg_q8 (angle_deg_q8)
    );

    // Valid bits shadow the datapath stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[TOTAL-2:0], s_tvalid};
    end

    // Output register with one skid entry
    assign pipe_data = {angle_deg_q8, magnitude_q4};
    assign pipe_beat = valid_reg[TOTAL-1] && adv;
    assign take      = out_valid_reg && m_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (pipe_beat)
                out_data_next = pipe_data;
            else
                out_valid_next = 1'b0;
        end
        else if (pipe_beat)
        begin
            if (!out_valid_reg)
            begin
                out_data_next  = pipe_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = pipe_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-OUT_W){1'b0}}, out_data_reg};

`ifndef ASSERT_OFF
    // Skid entry is only ever filled behind a waiting output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // A full skid entry holds while the master side stalls
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("skid entry lost during stall");

    // No pipeline beat may arrive while the skid entry is full
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_valid_reg && !m_tready) |=> !(skid_valid_reg && pipe_beat))
        else $error("pipeline advanced into a full output buffer");

    // Delivered angle is wrapped and length within range
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[MAG_W +: ANG_W] < DEG360_Q8) &&
                      (m_tdata[MAG_W-1:0] <= MAG_MAX)))
        else $error("result field out of range");
`endif

endmodule

`default_nettype wire

// ===== sim/joystick_rect_to_polar_checker.sv =====
`timescale 1ns / 1ps

module joystick_rect_to_polar_checker
    import jrp_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // axis_x[15:0], axis_y[31:16]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // magnitude_q4[19:0], angle_deg_q8[36:20]
    output int                   mismatches,
    output int                   pending,
    output int                   results_checked
);

    // Angles in degrees with 16 fraction bits
    localparam longint RIGHT_ANGLE_Q16 = 64'd5898240;
    localparam longint HALF_TURN_Q16   = 64'd11796480;
    localparam longint FULL_TURN_Q16   = 64'd23592960;
    localparam int     ARCTAN_ENTRIES  = 32;

    // One expected result, with the sample that caused it for reporting
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [MAG_W-1:0]   magnitude;
        logic [ANG_W-1:0]   angle;
    } polar_expect_t;

    polar_expect_t polar_expect_q [$];

    // atan(2^-i) in degrees, 16 fraction bits
    longint arctan_step_q16 [0:ARCTAN_ENTRIES-1] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    // Integer square root, rounded down
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res;
        longint unsigned step;
        res  = 0;
        step = 64'd1 << 62;
        while (step > v)
            step >>= 2;
        while (step != 0)
        begin
            if (v >= res + step)
            begin
                v   -= res + step;
                res  = (res >> 1) + step;
            end
            else
            begin
                res >>= 1;
            end
            step >>= 2;
        end
        return res;
    endfunction

    // Length with 4 fraction bits, rounded half up
    function automatic logic [MAG_W-1:0] predict_magnitude(input int x, input int y);
        longint unsigned sum_sq;
        longint unsigned len;
        sum_sq = longint'(x * x) + longint'(y * y);
        len    = (root_floor(sum_sq << 10) + 1) >> 1;
        return len[MAG_W-1:0];
    endfunction

    // First-quadrant direction of (ax, ay), both positive, clamped to 0..90 degrees
    function automatic longint quadrant_angle_q16(input longint ax, input longint ay);
        longint vx;
        longint vy;
        longint acc;
        longint dx;
        longint dy;
        vx  = ax <<< 14;
        vy  = ay <<< 14;
        acc = 0;
        for (int i = 0; i < CORDIC_STAGES && i < ARCTAN_ENTRIES; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0)
            begin
                vx  += dx;
                vy  -= dy;
                acc += arctan_step_q16[i];
            end
            else
            begin
                vx  -= dx;
                vy  += dy;
                acc -= arctan_step_q16[i];
            end
        end
        if (acc < 0)
            acc = 0;
        if (acc > RIGHT_ANGLE_Q16)
            acc = RIGHT_ANGLE_Q16;
        return acc;
    endfunction

    // Direction in degrees with 8 fraction bits, below 360
    function automatic logic [ANG_W-1:0] predict_angle(input int x, input int y);
        longint a;
        longint full;
        longint rounded;
        if (x == 0)
            return (y > 0) ? DEG90_Q8 : ((y < 0) ? DEG270_Q8 : DEG0_Q8);
        if (y == 0)
            return (x > 0) ? DEG0_Q8 : DEG180_Q8;
        a = quadrant_angle_q16((x < 0) ? -x : x, (y < 0) ? -y : y);
        if (x > 0 && y > 0)
            full = a;
        else if (x < 0 && y > 0)
            full = HALF_TURN_Q16 - a;
        else if (x < 0)
            full = HALF_TURN_Q16 + a;
        else
            full = FULL_TURN_Q16 - a;
        rounded = (full + 128) >>> 8;
        if (rounded >= longint'(DEG360_Q8))
            rounded -= longint'(DEG360_Q8);
        return rounded[ANG_W-1:0];
    endfunction

    // Predict on every slave beat, compare on every master beat
    always @(posedge clk)
    begin : watch
        polar_expect_t want;
        polar_expect_t made;
        logic [MAG_W-1:0] got_mag;
        logic [ANG_W-1:0] got_ang;
        int bad;
        if (rst_n)
        begin
            bad = 0;
            if (m_tvalid && m_tready)
            begin
                got_mag = m_tdata[MAG_W-1:0];
                got_ang = m_tdata[MAG_W +: ANG_W];
                if (polar_expect_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected: mag %0d ang %0d",
                             $time, got_mag, got_ang);
                    bad++;
                end
                else
                begin
                    want = polar_expect_q.pop_front();
                    if (got_mag !== want.magnitude)
                    begin
                        $display("%0t: magnitude for (%0d, %0d): expected %0d, actual %0d",
                                 $time, want.x, want.y, want.magnitude, got_mag);
                        bad++;
                    end
                    if (got_ang !== want.angle)
                    begin
                        $display("%0t: angle for (%0d, %0d): expected %0d, actual %0d",
                                 $time, want.x, want.y, want.angle, got_ang);
                        bad++;
                    end
                end
                results_checked <= results_checked + 1;
            end
            if (s_tvalid && s_tready)
            begin
                made.x         = s_tdata[15:0];
                made.y         = s_tdata[31:16];
                made.magnitude = predict_magnitude(made.x, made.y);
                made.angle     = predict_angle(made.x, made.y);
                polar_expect_q.push_back(made);
            end
            if (bad != 0)
                mismatches <= mismatches + bad;
            pending <= polar_expect_q.size();
        end
    end

endmodule

// ===== sim/joystick_rect_to_polar_tb.sv =====
`timescale 1ns / 1ps

module joystick_rect_to_polar_tb
    import jrp_pkg::*;
();

    localparam int STAGES       = 16;
    localparam int RANDOM_PAIRS = 1130;
    localparam int DRAIN_EVERY  = 400;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE       = 40;
    localparam int DIRECTED_N   = 23;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_CHOKED
    } rx_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;    // axis_x[15:0], axis_y[31:16]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // magnitude_q4[19:0], angle_deg_q8[36:20]

    int mismatches;
    int pending;
    int results_checked;
    int pairs_sent = 0;
    int quiet_cycles = 0;
    int rx_cycle = 0;

    // Axes, origin, corners, unit steps, near-axis and near-wrap samples
    int dir_x [0:DIRECTED_N-1] = '{
        0, 32767, -32768, 0, 0, 1, -1, 0, 0,
        32767, -32768, -32768, 32767,
        1, -1, -1, 1,
        32767, 1, -32768, -1, 3, 32767
    };
    int dir_y [0:DIRECTED_N-1] = '{
        0, 0, 0, 32767, -32768, 0, 0, 1, -1,
        32767, 32767, -32768, -32768,
        1, 1, -1, -1,
        1, 32767, -1, -32768, -4, -1
    };

    always #2 clk = ~clk;

    joystick_rect_to_polar #(
        .CORDIC_STAGES (STAGES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    joystick_rect_to_polar_checker #(
        .CORDIC_STAGES (STAGES)
    ) polar_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    // Receiver back-pressure: the pattern is chosen by bits 9:8 of the cycle counter
    always @(negedge clk)
    begin : rx_stall
        logic [1:0] phase;
        phase = rx_cycle[9:8];
        rx_cycle <= rx_cycle + 1;
        case (phase)
            RX_OPEN:     m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_tready <= (rx_cycle[2:0] < 5);
            RX_CHOKED:   m_tready <= ($urandom_range(0, 3) == 0);
            default:     m_tready <= 1'b1;
        endcase
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(negedge clk)
    begin
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    function automatic int clip16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat
    task automatic send_pair(input int x, input int y);
        s_tdata  <= {y[15:0], x[15:0]};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        pairs_sent++;
    endtask

    // Hold off until every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // Mix of full-range, small, near-axis, near-diagonal and extreme samples
    task automatic random_pair(output int x, output int y);
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        int pick;
        int extremes [0:5];
        extremes = '{-32768, -32767, -1, 0, 1, 32767};
        rx   = 16'($urandom);
        ry   = 16'($urandom);
        x    = rx;
        y    = ry;
        pick = $urandom_range(0, 9);
        case (pick)
            4:
            begin
                x = $urandom_range(0, 32) - 16;
                y = $urandom_range(0, 32) - 16;
            end
            5: y = $urandom_range(0, 6) - 3;
            6: x = $urandom_range(0, 6) - 3;
            7:
            begin
                y = ($urandom_range(0, 1) != 0) ? x : -x;
                y = clip16(y + $urandom_range(0, 6) - 3);
            end
            8:
            begin
                x = extremes[$urandom_range(0, 5)];
                y = extremes[$urandom_range(0, 5)];
            end
            9:
            begin
                if ($urandom_range(0, 1) != 0)
                    x = 0;
                else
                    y = 0;
            end
            default: ;
        endcase
    endtask

    initial
    begin
        int x;
        int y;
        int burst_left;
        burst_left = 0;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed samples back to back
        for (int i = 0; i < DIRECTED_N; i++)
            send_pair(dir_x[i], dir_y[i]);
        wait_drained();

        // Random samples in bursts, draining now and then
        for (int n = 0; n < RANDOM_PAIRS; n++)
        begin
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
                wait_drained();
            if (burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                if ($urandom_range(0, 7) == 0)
                    burst_left = $urandom_range(100, 250);
                else
                    burst_left = $urandom_range(1, 30);
            end
            random_pair(x, y);
            send_pair(x, y);
            burst_left--;
        end

        wait_drained();
        repeat (SETTLE) @(negedge clk);

        $display("sent %0d stick samples: origin, axes, corners, all quadrants, random bursts",
                 pairs_sent);
        $display("checked %0d polar results under output stalls, %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
